@@ design/llcs_pkg.sv @@
// Package for the luma log contrast stretch block: constants, state enum,
// controller/datapath command struct and the Lm log function for the lookup table.
// No dependencies.
package llcs_pkg;

  localparam int LogFracBitsDef = 12;
  localparam int LumaW          = 8;
  localparam int DivSteps       = 9;  // quotient of 2*255*num/(2*den) fits in 9 bits

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } llcs_state_t;

  typedef struct packed {
    logic load;     // capture pixel on every accepted beat
    logic step;     // one divider iteration
    logic emit;     // results valid
  } llcs_cmd_t;

  // Lm(n) = round(2^fb * log2(n+1)) computed exactly as the bit-serial
  // squaring method; elaborated into a constant table.
  function automatic logic [31:0] log_q(input int n, input int fb);
    logic [63:0] x;
    logic [63:0] frac;
    logic [63:0] total;
    int m;
    int e;
    m = (n & 255) + 1;
    e = 0;
    while (e < 8 && (m >> (e + 1)) != 0) e++;
    x = 64'(m) << (30 - e);
    frac = '0;
    for (int i = 1; i <= 28; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac = frac | (64'd1 << (28 - i));
      end
    end
    total = (64'(e) << 28) | frac;
    total = (total + (64'd1 << (27 - fb))) >> (28 - fb);
    return total[31:0];
  endfunction

endpackage

@@ design/llcs_ctrl.sv @@
// Controller FSM: sequences load, serial divide and output handoff.
// Depends on llcs_pkg.
module llcs_ctrl import llcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  input  logic      out_stall,
  output logic      in_stall,
  output logic      out_valid,
  output llcs_cmd_t cmd
);

  llcs_state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        take;

  assign take = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (take && in_command) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(DivSteps - 1)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    cmd.load  = (state_r == ST_IDLE) && take;
    cmd.step  = (state_r == ST_DIV);
    cmd.emit  = (state_r == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ design/llcs_dp.sv @@
// Datapath: luma/chroma, min/max tracking, log table, restoring divider
// and BGR reconstruction with clamp. Depends on llcs_pkg.
module llcs_dp import llcs_pkg::*; #(
  parameter int LOG_FRAC_BITS = LogFracBitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_command,
  input  logic       in_frame_start,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  input  llcs_cmd_t  cmd,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red
);

  localparam int LW = LOG_FRAC_BITS + 4;   // Lm max = 8*2^fb
  localparam int NW = LW + 9;              // 510*num
  localparam int DW = LW + 1;              // 2*den

  logic [LW-1:0] lut [256];
  for (genvar i = 0; i < 256; i++) begin : g_lut
    assign lut[i] = LW'(log_q(i, LOG_FRAC_BITS));
  end

  logic [7:0]  lmin_r, lmax_r, y;
  logic [15:0] ysum;
  assign ysum = 16'(16'd29 * in_blue + 16'd150 * in_green + 16'd77 * in_red + 16'd128);
  assign y    = ysum[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lmin_r <= 8'd255;
      lmax_r <= 8'd0;
    end else if (in_valid && !in_stall && !in_command) begin
      if (in_frame_start) begin
        lmin_r <= y;
        lmax_r <= y;
      end else begin
        if (y < lmin_r) lmin_r <= y;
        if (y > lmax_r) lmax_r <= y;
      end
    end
  end

  logic signed [17:0] u, v;
  assign u = 18'sd112 * $signed({10'd0, in_blue}) - 18'sd74 * $signed({10'd0, in_green})
           - 18'sd38 * $signed({10'd0, in_red});
  assign v = 18'sd157 * $signed({10'd0, in_red}) - 18'sd26 * $signed({10'd0, in_blue})
           - 18'sd132 * $signed({10'd0, in_green});

  logic [LW-1:0] lmy, lmn, lmx, num, den;
  assign lmy = lut[y];
  assign lmn = lut[lmin_r];
  assign lmx = lut[lmax_r];
  assign den = lmx - lmn;
  always_comb begin
    if (lmy <= lmn)      num = '0;
    else if (lmy >= lmx) num = den;
    else                 num = lmy - lmn;
  end

  // Restoring divider: (510*num + den) / (2*den), one quotient bit per step.
  // Quotient < 2^9, so the dividend bits above the low 9 are already below
  // the divisor and seed the remainder at load; only 9 steps remain.
  logic signed [17:0] u_r, v_r;
  logic [NW-1:0]      dvd_r;
  logic [DW-1:0]      dvs_r;
  logic [NW:0]        rem_r;
  logic [8:0]         q_r;
  logic               flat_r;
  logic [NW:0]        trial;
  logic [NW-1:0]      dvd_init;

  assign dvd_init = NW'(num) * NW'(510) + NW'(den);
  assign trial = {rem_r[NW-1:0], dvd_r[NW-1]} - (NW+1)'(dvs_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_r    <= u;
      v_r    <= v;
      flat_r <= (lmax_r <= lmin_r);
      dvd_r  <= {dvd_init[DivSteps-1:0], (NW-DivSteps)'(0)};
      dvs_r  <= {den, 1'b0};
      rem_r  <= (NW+1)'(dvd_init[NW-1:DivSteps]);
      q_r    <= '0;
    end else if (cmd.step) begin
      // remainder stays below divisor; shift in remaining dividend bits
      if (!trial[NW]) rem_r <= trial;
      else            rem_r <= {rem_r[NW-1:0], dvd_r[NW-1]};
      q_r   <= {q_r[7:0], !trial[NW]};
      dvd_r <= dvd_r << 1;
    end
  end

  logic [8:0]          yn;
  logic signed [27:0]  base, sb, sg, sr;
  assign yn   = flat_r ? 9'd0 : q_r;
  assign base = $signed({3'd0, yn, 16'd0}) + 28'sd32768;
  assign sb   = base + 28'sd520 * 28'(u_r);
  assign sg   = base - 28'sd101 * 28'(u_r) - 28'sd149 * 28'(v_r);
  assign sr   = base + 28'sd292 * 28'(v_r);

  function automatic logic [7:0] clampc(input logic signed [27:0] s);
    if (s < 0) return 8'd0;
    if (s[27:16] > 12'd255) return 8'd255;
    return s[23:16];
  endfunction

  assign out_blue  = clampc(sb);
  assign out_green = clampc(sg);
  assign out_red   = clampc(sr);

endmodule

@@ design/luma_log_contrast_stretch_core.sv @@
// Top level of the luma log contrast stretch block.
// A measure beat updates the luma range and gives no result. A transform beat
// passes IDLE, DIV and OUT; no beat is taken until IDLE again. Measure beats:
// one per cycle while idle. The 9-step serial divider sets the transform rate.
// Reset (rst_n low, synchronous): FSM idle, luma_min=255, luma_max=0.
module luma_log_contrast_stretch_core import llcs_pkg::*; #(
  parameter int LOG_FRAC_BITS = LogFracBitsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic       in_frame_start,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red
);

  llcs_cmd_t cmd;

  llcs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_command, .out_stall,
    .in_stall, .out_valid, .cmd
  );

  llcs_dp #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_dp (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_frame_start,
    .in_blue, .in_green, .in_red, .cmd, .out_blue, .out_green, .out_red
  );

  // a transform beat accepted is followed by busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command |=> in_stall) else $error("no busy");
  // result never shown while input is being taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("overlap");
  // held result stays stable
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_blue)) else $error("drop");

endmodule

@@ tb/tb_top.sv @@
// Testbench for luma_log_contrast_stretch_core: drives measure and transform
// beats, predicts each stretched pixel and checks the result channel.
// Depends on llcs_pkg (only through the block's RTL) and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit CmdMeasure   = 1'b0;
  localparam bit CmdTransform = 1'b1;
  localparam int FracBits     = 12;
  localparam int WatchLimit   = 20000;

  // Expected stretched pixels, oldest first; the luma range lives here too.
  class stretch_board;
    logic [7:0] luma_lo;
    logic [7:0] luma_hi;
    logic [23:0] pending[$];
    int errors;

    function new();
      luma_lo = 8'd255;
      luma_hi = 8'd0;
      errors = 0;
    endfunction

    // Lm(n) by repeated squaring, Q28 then rounded to FracBits.
    function longint log_fixed(int n);
      longint unsigned x;
      longint unsigned frac;
      longint unsigned total;
      int m;
      int e;
      m = (n & 255) + 1;
      e = 0;
      frac = 0;
      while (e < 8 && (m >> (e + 1)) != 0) e++;
      x = longint'(m) << (30 - e);
      for (int i = 1; i <= 28; i++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          frac = frac | (64'd1 << (28 - i));
        end
      end
      total = (longint'(e) << 28) | frac;
      total = (total + (64'd1 << (27 - FracBits))) >> (28 - FracBits);
      return longint'(total);
    endfunction

    function logic [7:0] clamp_chan(longint s);
      longint v;
      if (s < 0) return 8'd0;
      v = s >>> 16;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void note_pixel(bit cmd, bit fs, logic [7:0] b, logic [7:0] g,
                             logic [7:0] r);
      logic [7:0] y;
      longint u, v, yn, num, den, base;
      y = 8'((29 * int'(b) + 150 * int'(g) + 77 * int'(r) + 128) >> 8);
      if (cmd == CmdMeasure) begin
        if (fs) begin
          luma_lo = y;
          luma_hi = y;
        end else begin
          if (y < luma_lo) luma_lo = y;
          if (y > luma_hi) luma_hi = y;
        end
        return;
      end
      u = 112 * longint'(b) - 74 * longint'(g) - 38 * longint'(r);
      v = -26 * longint'(b) - 132 * longint'(g) + 157 * longint'(r);
      if (luma_hi <= luma_lo) yn = 0;
      else begin
        den = log_fixed(luma_hi) - log_fixed(luma_lo);
        num = log_fixed(y) - log_fixed(luma_lo);
        if (num < 0) num = 0;
        if (num > den) num = den;
        yn = (2 * 255 * num + den) / (2 * den);
      end
      base = yn * 65536 + 32768;
      pending.push_back({clamp_chan(base + 520 * u),
                         clamp_chan(base - 101 * u - 149 * v),
                         clamp_chan(base + 292 * v)});
    endfunction

    function void check_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      logic [23:0] want;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %0d %0d %0d", b, g, r);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (b !== want[23:16]) begin
        $error("out_blue expected %0d actual %0d", want[23:16], b);
        errors++;
      end
      if (g !== want[15:8]) begin
        $error("out_green expected %0d actual %0d", want[15:8], g);
        errors++;
      end
      if (r !== want[7:0]) begin
        $error("out_red expected %0d actual %0d", want[7:0], r);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, in_command, in_frame_start;
  logic [7:0] in_blue, in_green, in_red;
  logic out_valid, out_stall;
  logic [7:0] out_blue, out_green, out_red;

  stretch_board board;
  bit hold_off;      // long receiver hold-off request
  int idle_cycles;   // watchdog: cycles without any accepted beat

  luma_log_contrast_stretch_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_frame_start(in_frame_start),
    .in_blue(in_blue), .in_green(in_green), .in_red(in_red),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Send one beat: random gap first (none with no_gap), then hold until the block takes it.
  task automatic send_pixel(bit cmd, bit fs, logic [7:0] b, logic [7:0] g,
                            logic [7:0] r, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_frame_start <= fs;
    in_blue <= b;
    in_green <= g;
    in_red <= r;
    do @(posedge clk); while (in_stall);
    board.note_pixel(cmd, fs, b, g, r);
    @(negedge clk);
  endtask

  task automatic send_random(bit cmd, bit fs, bit no_gap);
    send_pixel(cmd, fs, 8'($urandom), 8'($urandom), 8'($urandom), no_gap);
  endtask

  // A frame: measure pass over some pixels, then a transform pass.
  // Random frames mostly stay in a narrow color region so ranges vary.
  task automatic send_frame(int pixels, bit no_gap);
    logic [7:0] px_b[$], px_g[$], px_r[$];
    int lo, span;
    lo = $urandom_range(0, 255);
    span = $urandom_range(0, 255 - lo);
    for (int i = 0; i < pixels; i++) begin
      px_b.push_back(8'($urandom_range(lo, lo + span)));
      px_g.push_back(8'($urandom_range(lo, lo + span)));
      px_r.push_back(8'($urandom_range(lo, lo + span)));
    end
    for (int i = 0; i < pixels; i++)
      send_pixel(CmdMeasure, i == 0, px_b[i], px_g[i], px_r[i], no_gap);
    for (int i = 0; i < pixels; i++) begin
      // stray frame_start on a transform beat must be ignored
      send_pixel(CmdTransform, $urandom_range(0, 15) == 0,
                 px_b[i], px_g[i], px_r[i], no_gap);
    end
  endtask

  // Receiver: random stall per beat, or a long hold-off on request.
  initial begin
    int wait_n;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Check every result beat at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_pixel(out_blue, out_green, out_red);
  end

  // Watchdog on beats accepted on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int settle;
    board = new();
    hold_off = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CmdMeasure;
    in_frame_start = 1'b0;
    in_blue = 8'd0;
    in_green = 8'd0;
    in_red = 8'd0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: transform before any measure gives the empty-range case.
    send_pixel(CmdTransform, 1'b0, 8'd255, 8'd0, 8'd128, 1'b0);
    send_pixel(CmdTransform, 1'b1, 8'd0, 8'd255, 8'd0, 1'b0);
    // Flat range: one measured gray pixel.
    send_pixel(CmdMeasure, 1'b1, 8'd100, 8'd100, 8'd100, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd100, 8'd100, 8'd100, 1'b0);
    // Full range black to white, then extremes and saturated colors.
    send_pixel(CmdMeasure, 1'b1, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(CmdMeasure, 1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd255, 8'd255, 8'd0, 1'b0);
    // Narrow range with luma outside it on both sides (clamped).
    send_pixel(CmdMeasure, 1'b1, 8'd90, 8'd90, 8'd90, 1'b0);
    send_pixel(CmdMeasure, 1'b0, 8'd120, 8'd120, 8'd120, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd10, 8'd10, 8'd10, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd250, 8'd250, 8'd250, 1'b0);
    send_pixel(CmdTransform, 1'b1, 8'd105, 8'd105, 8'd105, 1'b0);
    send_pixel(CmdTransform, 1'b0, 8'd0, 8'd128, 8'd255, 1'b0);

    // Pressure: receiver holds off while sender keeps offering beats.
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_random(CmdTransform, 1'b0, 1'b1);

    // Sender pauses until every expected result has come.
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);

    // Random: mostly well-formed frames, some loose noise beats.
    for (int n = 0; n < 530; ) begin
      if ($urandom_range(0, 4) == 0) begin
        send_random($urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
        n++;
      end else begin
        settle = $urandom_range(1, 12);
        send_frame(settle, $urandom_range(0, 4) == 0);
        n += 2 * settle;
      end
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
